@@ rtl/core/nfba_pkg.sv @@
// Shared types and codes for the next-fit bitmap entry allocator.
`default_nettype none

package nfba_pkg;

  // Width of the entry number fields on the request and result ports.
  localparam int ENTRY_IDX_W = 13;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_ALLOCATED = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_FREED     = 2'd2,
    STATUS_IGNORED   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_GRANT,
    ST_DIV,
    ST_FREE_RD,
    ST_FREE_WR
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/next_fit_bitmap_entry_allocator.sv @@
// Next-fit bitmap allocator for descriptor table entries: sequencer and bitmap memory.
`default_nettype none

// A request is taken when start is high and busy is low; its single result appears on the
// out_ ports for one cycle, marked by out_valid, and the receiver cannot stall it. The block
// handles one request at a time and keeps busy high until the result has been registered.
// After reset the bitmap memory is cleared one word per cycle with busy high. An allocate
// request scans the bitmap one word per cycle, but for a pause when it wraps round, through
// the memory's single read port, starting at the word that holds the search hint and, if
// nothing is free there or above, again from word zero up to the hint's word. A free entry
// is marked used in the grant state, which registers the result; a full table is reported
// as the wrap pass ends. A free request first splits the entry number into word and bit: a
// multiplication by the reciprocal of WORD_BITS gives the word in the divide state, the bit
// follows from it in the free-read state while the word is read from the bitmap, and the
// word is written back with the bit cleared in the free-write state, which registers the
// result. A free of an entry outside the table is answered with status "ignored" in the
// cycle after it is taken, and busy stays low.
module next_fit_bitmap_entry_allocator #(
  parameter int ENTRY_COUNT = 8192,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_kind,
  input  wire logic [nfba_pkg::ENTRY_IDX_W-1:0]   in_entry_index,
  output logic                                    out_valid,
  output logic      [nfba_pkg::ENTRY_IDX_W-1:0]   out_granted_entry,
  output logic      [1:0]                         out_status
);

  // Geometry of the bitmap.
  localparam int WORD_COUNT = (ENTRY_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int LAST_BITS  = ENTRY_COUNT - (WORD_COUNT - 1) * WORD_BITS;
  localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WCW        = $clog2(WORD_COUNT + 1);
  localparam int BW         = $clog2(WORD_BITS);
  localparam int EW         = $clog2(ENTRY_COUNT);
  localparam int OUT_W      = nfba_pkg::ENTRY_IDX_W;
  localparam int CMPW       = (OUT_W + 1 > $clog2(ENTRY_COUNT + 1)) ?
                              OUT_W + 1 : $clog2(ENTRY_COUNT + 1);

  // Reciprocal of WORD_BITS, rounded up, scaled so that the quotient is exact for every
  // EW-bit entry number.
  localparam int QSH = EW + BW;
  localparam int RW  = EW + 2;
  localparam int PW  = EW + RW;
  localparam logic [RW-1:0] RECIP = RW'(((1 << QSH) + WORD_BITS - 1) / WORD_BITS);

  // Bits of the last word that lie inside the table.
  localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
  localparam logic [WORD_BITS-1:0] ALL_MASK  = {WORD_BITS{1'b1}};

  // Lowest set bit of a word.
  function automatic logic [BW-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BW'(i);
      end
    end
    return r;
  endfunction

  // Sequencer and control state.
  nfba_pkg::state_t  state_r,       state_nxt;
  logic [WCW-1:0]    iss_r,         iss_nxt;
  logic              phase_r,       phase_nxt;
  logic              chk_vld_r,     chk_vld_nxt;
  logic [WAW-1:0]    chk_addr_r,    chk_addr_nxt;
  logic              chk_first_r,   chk_first_nxt;
  logic [WAW-1:0]    hint_word_r,   hint_word_nxt;
  logic [BW-1:0]     hint_bit_r,    hint_bit_nxt;
  logic              out_valid_r,   out_valid_nxt;

  // Payload registers.
  logic [WAW-1:0]        found_word_r,  found_word_nxt;
  logic [BW-1:0]         found_bit_r,   found_bit_nxt;
  logic [WORD_BITS-1:0]  found_data_r,  found_data_nxt;
  logic [EW-1:0]         dvd_r,         dvd_nxt;
  logic [WAW-1:0]        quo_r,         quo_nxt;
  logic [BW-1:0]         rem_r,         rem_nxt;
  logic [OUT_W-1:0]      out_granted_r, out_granted_nxt;
  nfba_pkg::status_t     out_status_r,  out_status_nxt;

  // Bitmap memory.
  logic [WORD_BITS-1:0]  mem_q [WORD_COUNT];
  logic [WORD_BITS-1:0]  rd_data_r;
  logic                  mem_we;
  logic [WAW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [WAW-1:0]        mem_raddr;

  // Datapath helpers.
  logic                  accept;
  logic                  idx_out_of_range;
  logic                  issue_ok;
  logic                  chk_last;
  logic [WORD_BITS-1:0]  free_vec;
  logic [EW-1:0]         gnt_entry;
  logic [PW-1:0]         div_prod;
  logic [WAW-1:0]        q_word;
  logic                  free_below_hint;

  assign busy      = (state_r != nfba_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_granted_entry = out_granted_r;
  assign out_status        = out_status_r;

  assign idx_out_of_range = (CMPW'(in_entry_index) >= CMPW'(ENTRY_COUNT));

  // The scan issues one word read per cycle; the wrap pass stops at the hint's word.
  assign issue_ok = phase_r ? (iss_r <= WCW'(hint_word_r)) : (iss_r < WCW'(WORD_COUNT));
  assign chk_last = (chk_addr_r == WAW'(WORD_COUNT - 1));
  assign free_vec = ~rd_data_r
                  & (chk_last ? LAST_MASK : ALL_MASK)
                  & (chk_first_r ? (ALL_MASK << hint_bit_r) : ALL_MASK);

  // Entry number of the granted bit; it is always below ENTRY_COUNT, so EW bits suffice.
  assign gnt_entry = EW'(found_word_r) * EW'(WORD_BITS) + EW'(found_bit_r);

  // Word number of the entry being freed, by multiplying with the scaled reciprocal.
  assign div_prod = {{RW{1'b0}}, dvd_r} * {{EW{1'b0}}, RECIP};

  // Once the split is done, quo_r holds the word and rem_r the bit.
  assign q_word          = quo_r;
  assign free_below_hint = (q_word < hint_word_r) ||
                           ((q_word == hint_word_r) && (rem_r < hint_bit_r));

  assign mem_raddr = (state_r == nfba_pkg::ST_SCAN) ? iss_r[WAW-1:0] : q_word;

  always_comb begin
    state_nxt       = state_r;
    iss_nxt         = iss_r;
    phase_nxt       = phase_r;
    chk_vld_nxt     = 1'b0;
    chk_addr_nxt    = chk_addr_r;
    chk_first_nxt   = chk_first_r;
    hint_word_nxt   = hint_word_r;
    hint_bit_nxt    = hint_bit_r;
    out_valid_nxt   = 1'b0;
    found_word_nxt  = found_word_r;
    found_bit_nxt   = found_bit_r;
    found_data_nxt  = found_data_r;
    dvd_nxt         = dvd_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    mem_waddr       = found_word_r;
    mem_wdata       = found_data_r;

    unique case (state_r)
      nfba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = iss_r[WAW-1:0];
        mem_wdata = '0;
        iss_nxt   = iss_r + WCW'(1);
        if (iss_r == WCW'(WORD_COUNT - 1)) begin
          state_nxt = nfba_pkg::ST_IDLE;
        end
      end

      nfba_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == nfba_pkg::KIND_ALLOC) begin
            iss_nxt   = WCW'(hint_word_r);
            phase_nxt = 1'b0;
            state_nxt = nfba_pkg::ST_SCAN;
          end else if (idx_out_of_range) begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = '0;
            out_status_nxt  = nfba_pkg::STATUS_IGNORED;
          end else begin
            dvd_nxt   = EW'(in_entry_index);
            state_nxt = nfba_pkg::ST_DIV;
          end
        end
      end

      nfba_pkg::ST_SCAN: begin
        chk_vld_nxt   = issue_ok;
        chk_addr_nxt  = iss_r[WAW-1:0];
        chk_first_nxt = !phase_r && (iss_r == WCW'(hint_word_r));
        if (issue_ok) begin
          iss_nxt = iss_r + WCW'(1);
        end
        if (chk_vld_r) begin
          if (|free_vec) begin
            found_word_nxt = chk_addr_r;
            found_bit_nxt  = first_one(free_vec);
            found_data_nxt = rd_data_r;
            state_nxt      = nfba_pkg::ST_GRANT;
          end else if (!phase_r && chk_last) begin
            // Nothing at or above the hint: wrap round and search from word zero.
            phase_nxt   = 1'b1;
            iss_nxt     = '0;
            chk_vld_nxt = 1'b0;
          end else if (phase_r && (chk_addr_r == hint_word_r)) begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = '0;
            out_status_nxt  = nfba_pkg::STATUS_FULL;
            state_nxt       = nfba_pkg::ST_IDLE;
          end
        end
      end

      nfba_pkg::ST_GRANT: begin
        mem_we          = 1'b1;
        mem_waddr       = found_word_r;
        mem_wdata       = found_data_r | (WORD_BITS'(1) << found_bit_r);
        out_valid_nxt   = 1'b1;
        out_granted_nxt = OUT_W'(gnt_entry);
        out_status_nxt  = nfba_pkg::STATUS_ALLOCATED;
        if ((found_word_r == WAW'(WORD_COUNT - 1)) &&
            (found_bit_r == BW'(LAST_BITS - 1))) begin
          hint_word_nxt = '0;
          hint_bit_nxt  = '0;
        end else if (found_bit_r == BW'(WORD_BITS - 1)) begin
          hint_word_nxt = found_word_r + WAW'(1);
          hint_bit_nxt  = '0;
        end else begin
          hint_word_nxt = found_word_r;
          hint_bit_nxt  = found_bit_r + BW'(1);
        end
        state_nxt = nfba_pkg::ST_IDLE;
      end

      nfba_pkg::ST_DIV: begin
        quo_nxt   = WAW'(div_prod >> QSH);
        state_nxt = nfba_pkg::ST_FREE_RD;
      end

      nfba_pkg::ST_FREE_RD: begin
        // The bit is below WORD_BITS, so the low bits of the difference are exact.
        rem_nxt   = BW'(dvd_r) - BW'(quo_r) * BW'(WORD_BITS);
        state_nxt = nfba_pkg::ST_FREE_WR;
      end

      nfba_pkg::ST_FREE_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = q_word;
        mem_wdata       = rd_data_r & ~(WORD_BITS'(1) << rem_r);
        out_valid_nxt   = 1'b1;
        out_granted_nxt = '0;
        out_status_nxt  = nfba_pkg::STATUS_FREED;
        if (free_below_hint) begin
          hint_word_nxt = q_word;
          hint_bit_nxt  = rem_r;
        end
        state_nxt = nfba_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = nfba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfba_pkg::ST_CLEAR;
      iss_r       <= '0;
      phase_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      chk_addr_r  <= '0;
      chk_first_r <= 1'b0;
      hint_word_r <= '0;
      hint_bit_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      phase_r     <= phase_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_addr_r  <= chk_addr_nxt;
      chk_first_r <= chk_first_nxt;
      hint_word_r <= hint_word_nxt;
      hint_bit_r  <= hint_bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_word_r  <= found_word_nxt;
    found_bit_r   <= found_bit_nxt;
    found_data_r  <= found_data_nxt;
    dvd_r         <= dvd_nxt;
    quo_r         <= quo_nxt;
    rem_r         <= rem_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_q[mem_raddr];
  end

  // The hint never points past the last entry of the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    (hint_word_r == WAW'(WORD_COUNT - 1)) |-> (32'(hint_bit_r) < LAST_BITS))
    else $error("search hint lies beyond the table");

  // A grant always takes a bit that was free when the word was read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::ST_GRANT) |-> !found_data_r[found_bit_r])
    else $error("granted entry was already in use");

  // Every grant is reported as an allocation in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::ST_GRANT) |=>
      (out_valid_r && (out_status_r == nfba_pkg::STATUS_ALLOCATED)))
    else $error("grant not reported");

  // No result is produced while the bitmap is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::ST_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  // The wrap-round pass never reads beyond the hint's word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (chk_vld_r && phase_r) |-> (chk_addr_r <= hint_word_r))
    else $error("wrap-round scan overran the hint");

endmodule

`default_nettype wire

@@ tb/sv/next_fit_bitmap_entry_allocator_tb.sv @@
// Self-checking testbench for the next-fit bitmap entry allocator.
`default_nettype none

module next_fit_bitmap_entry_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built at its default size, so the predictor uses the same geometry.
  localparam int TBL_ENTRIES  = 8192;
  localparam int TBL_WORDBITS = 32;
  localparam int MIXED_ITEMS  = 590;   // random requests in each of the three idling phases
  localparam int BATCH_LEN    = 16;
  localparam int SETTLE_WAIT  = 300;   // a little above the worst allocate latency
  localparam int RUN_LIMIT_NS = 60_000_000;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic                             kind;
    logic [nfba_pkg::ENTRY_IDX_W-1:0] entry;
  } alloc_req_t;

  typedef struct packed {
    logic [nfba_pkg::ENTRY_IDX_W-1:0] granted;
    nfba_pkg::status_t                status;
  } alloc_result_t;

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             start          = 1'b0;
  logic                             in_kind        = nfba_pkg::KIND_ALLOC;
  logic [nfba_pkg::ENTRY_IDX_W-1:0] in_entry_index = '0;
  logic                             busy;
  logic                             out_valid;
  logic [nfba_pkg::ENTRY_IDX_W-1:0] out_granted_entry;
  logic [1:0]                       out_status;

  // Requests waiting to be offered, and the results the block still owes us, oldest first.
  alloc_req_t    pending_reqs[$];
  alloc_result_t owed_results[$];

  // Entries the predictor has handed out; frees are mostly drawn from here so that the
  // bitmap keeps churning rather than filling up with random traffic.
  int live_entries[$];

  // Predictor state: one used bit per entry and the next-fit start point.
  bit [TBL_ENTRIES-1:0] used_map;
  int                   next_hint;

  int sender_idle_pct = 0;
  int mismatch_count  = 0;

  next_fit_bitmap_entry_allocator #(
    .ENTRY_COUNT(TBL_ENTRIES),
    .WORD_BITS  (TBL_WORDBITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_granted_entry(out_granted_entry),
    .out_status       (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // First free entry at or above the given one, or TBL_ENTRIES when there is none.
  function automatic int first_free_from(input int from);
    for (int e = from; e < TBL_ENTRIES; e++) begin
      if (!used_map[e]) return e;
    end
    return TBL_ENTRIES;
  endfunction

  // Applies one taken request to the predictor's state and records the result it must give.
  function automatic void apply_request(input alloc_req_t req);
    alloc_result_t res;
    int            e;
    res.granted = '0;
    res.status  = nfba_pkg::STATUS_ALLOCATED;
    if (req.kind == nfba_pkg::KIND_ALLOC) begin
      // Next fit: search from the hint upwards, and only then from the bottom of the table.
      e = first_free_from(next_hint);
      if (e >= TBL_ENTRIES) e = first_free_from(0);
      if (e >= TBL_ENTRIES) begin
        // A full table leaves everything as it was.
        res.status = nfba_pkg::STATUS_FULL;
      end else begin
        used_map[e] = 1'b1;
        next_hint   = (e + 1 >= TBL_ENTRIES) ? 0 : e + 1;
        res.granted = e[nfba_pkg::ENTRY_IDX_W-1:0];
        live_entries.push_back(e);
      end
    end else if (int'(req.entry) >= TBL_ENTRIES) begin
      res.status = nfba_pkg::STATUS_IGNORED;
    end else begin
      // Freeing an entry that is already free is legal; the hint is still pulled down.
      used_map[req.entry] = 1'b0;
      if (int'(req.entry) < next_hint) next_hint = int'(req.entry);
      res.status = nfba_pkg::STATUS_FREED;
    end
    owed_results.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: offers queued requests, holding each one until the block takes it.
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin
    alloc_req_t taken;
    alloc_req_t nxt;
    if (!rst_n) begin
      start          <= 1'b0;
      in_kind        <= nfba_pkg::KIND_ALLOC;
      in_entry_index <= '0;
    end else begin
      // A request is taken at an edge where start is high and busy is low; the predictor
      // works on it at that same edge, long before its result can appear.
      if (start && !busy) begin
        taken.kind  = in_kind;
        taken.entry = in_entry_index;
        apply_request(taken);
      end
      // Once the slot is free, either offer the next request or leave a gap.
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt             = pending_reqs.pop_front();
          start          <= 1'b1;
          in_kind        <= nxt.kind;
          in_entry_index <= nxt.entry;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: every strobed result is compared with the oldest owed one.
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: entry %0d status %0d",
                                  out_granted_entry, out_status));
      end else begin
        exp_res = owed_results.pop_front();
        if (out_granted_entry !== exp_res.granted || out_status !== exp_res.status) begin
          report_mismatch($sformatf(
            "result wrong: expected entry %0d status %0d, got entry %0d status %0d",
            exp_res.granted, exp_res.status, out_granted_entry, out_status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  task automatic queue_request(input logic kind,
                               input logic [nfba_pkg::ENTRY_IDX_W-1:0] entry);
    alloc_req_t req;
    req.kind  = kind;
    req.entry = entry;
    pending_reqs.push_back(req);
  endtask

  // Polls on the falling edge so that the driver's work at the rising edge has settled.
  task automatic wait_requests_taken();
    do @(negedge clk); while (pending_reqs.size() != 0 || start);
  endtask

  task automatic wait_results_settled();
    do @(negedge clk); while (owed_results.size() != 0);
  endtask

  // Mostly allocate/free pairs on live entries with random content, plus some frees of
  // arbitrary entry numbers, which exercise double frees and every bit of the index.
  task automatic run_mixed_traffic(input int count);
    int pick;
    int slot;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 52 || (pick < 90 && live_entries.size() == 0)) begin
        queue_request(nfba_pkg::KIND_ALLOC, nfba_pkg::ENTRY_IDX_W'($urandom));
      end else if (pick < 90) begin
        slot = $urandom_range(live_entries.size() - 1);
        queue_request(nfba_pkg::KIND_FREE, nfba_pkg::ENTRY_IDX_W'(live_entries[slot]));
        live_entries.delete(slot);
      end else begin
        queue_request(nfba_pkg::KIND_FREE, nfba_pkg::ENTRY_IDX_W'($urandom));
      end
      // Short batches keep the list of live entries close to the predictor's own view.
      if (n % BATCH_LEN == BATCH_LEN - 1) wait_requests_taken();
    end
    wait_requests_taken();
  endtask

  initial begin
    used_map  = '0;
    next_hint = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening on an empty table. The block is still clearing its bitmap after
    // reset, so these simply wait for busy to drop.
    sender_idle_pct = 0;
    repeat (4) queue_request(nfba_pkg::KIND_ALLOC, '0);  // entries 0 to 3
    queue_request(nfba_pkg::KIND_FREE, 13'd1);      // below the hint, so the hint drops to 1
    queue_request(nfba_pkg::KIND_FREE, 13'd1);      // entry already free
    queue_request(nfba_pkg::KIND_FREE, 13'd0);      // hint drops to the bottom of the table
    queue_request(nfba_pkg::KIND_ALLOC, '1);        // index is ignored on allocate
    queue_request(nfba_pkg::KIND_ALLOC, 13'h0AAA);
    queue_request(nfba_pkg::KIND_ALLOC, '0);        // next fit skips the used entries 2 and 3
    queue_request(nfba_pkg::KIND_FREE, '1);         // top entry, never allocated, above the hint
    queue_request(nfba_pkg::KIND_FREE, 13'h0AAA);
    queue_request(nfba_pkg::KIND_FREE, 13'h1555);
    queue_request(nfba_pkg::KIND_FREE, 13'd3);
    queue_request(nfba_pkg::KIND_FREE, 13'd2);
    repeat (3) queue_request(nfba_pkg::KIND_ALLOC, 13'h1555);
    wait_requests_taken();

    // Random traffic: a phase without gaps, one with a mostly idle sender, one in between.
    sender_idle_pct = 0;
    run_mixed_traffic(MIXED_ITEMS);
    sender_idle_pct = 76;
    run_mixed_traffic(MIXED_ITEMS);
    sender_idle_pct = 15;
    run_mixed_traffic(MIXED_ITEMS);

    // Let every owed result arrive, then watch a while longer for anything stray.
    wait_results_settled();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (owed_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("next_fit_bitmap_entry_allocator_tb: clean");
    end else begin
      $display("next_fit_bitmap_entry_allocator_tb: errors");
    end
    $finish;
  end

  // Guards against a block that stops answering.
  initial begin
    #(RUN_LIMIT_NS);
    $display("next_fit_bitmap_entry_allocator_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
